FILE: rtl/grb_pkg.sv
// Shared constants and types for the group reversal buffer.
`default_nettype none

package grb_pkg;

	localparam int MAX_GROUP = 16;                   // largest group held in one bank
	localparam int IDX_W     = $clog2(MAX_GROUP);    // entry index within a bank
	localparam int CNT_W     = $clog2(MAX_GROUP + 1); // values in a bank, 0..MAX_GROUP
	localparam int NBANK     = 2;                    // ping-pong banks
	localparam int BANK_W    = $clog2(NBANK);
	localparam int ADDR_W    = BANK_W + IDX_W;
	localparam int MEM_DEPTH = NBANK * MAX_GROUP;
	localparam int QCNT_W    = $clog2(NBANK + 1);    // run queue occupancy
	localparam int GS_W      = 5;                    // group_size register width
	localparam int CMP_W     = (CNT_W > GS_W) ? CNT_W : GS_W;
	localparam int VAL_W     = 32;

	localparam logic [GS_W-1:0] GS_RESET = GS_W'(2);

	// Write into the value store.
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [VAL_W-1:0]  data;
	} store_wr_t;

	// One finished run waiting to be drained.
	typedef struct packed {
		logic [BANK_W-1:0] bank;
		logic [CNT_W-1:0]  count;
		logic              rev;      // full group: emit newest first
		logic              seq_last; // run closes the sequence
	} run_desc_t;

endpackage

`default_nettype wire

FILE: rtl/grb_front.sv
// Front end: accepts values, fills the current bank and closes runs.
`default_nettype none

module grb_front (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire  [grb_pkg::GS_W-1:0]     cfg_wdata,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  [grb_pkg::VAL_W-1:0]    in_value,
	input  wire                          in_last,
	input  wire                          q_full,
	output logic                         q_push,
	output grb_pkg::run_desc_t           q_desc,
	output grb_pkg::store_wr_t           st_wr
);

	logic [grb_pkg::GS_W-1:0]   group_size_q;
	logic [grb_pkg::CNT_W-1:0]  fill_q;
	logic [grb_pkg::BANK_W-1:0] bank_q;

	logic [grb_pkg::CNT_W-1:0]  n;
	logic [grb_pkg::CMP_W-1:0]  gs_ext;
	logic [grb_pkg::CMP_W-1:0]  k;
	logic                       accept;
	logic                       full_group;
	logic                       close_run;

	always_comb begin
		gs_ext = grb_pkg::CMP_W'(group_size_q);
		// zero acts as one, oversize saturates
		if (gs_ext == '0) begin
			k = grb_pkg::CMP_W'(1);
		end else if (gs_ext > grb_pkg::CMP_W'(grb_pkg::MAX_GROUP)) begin
			k = grb_pkg::CMP_W'(grb_pkg::MAX_GROUP);
		end else begin
			k = gs_ext;
		end
	end

	assign in_ready   = !q_full;
	assign accept     = in_valid && in_ready;
	assign n          = fill_q + grb_pkg::CNT_W'(1);
	assign full_group = grb_pkg::CMP_W'(n) >= k;
	assign close_run  = full_group || in_last;

	assign st_wr.en   = accept;
	assign st_wr.addr = {bank_q, fill_q[grb_pkg::IDX_W-1:0]};
	assign st_wr.data = in_value;

	assign q_push          = accept && close_run;
	assign q_desc.bank     = bank_q;
	assign q_desc.count    = n;
	assign q_desc.rev      = full_group;
	assign q_desc.seq_last = in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= grb_pkg::GS_RESET;
		end else if (cfg_we) begin
			group_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			bank_q <= '0;
		end else if (accept) begin
			if (close_run) begin
				fill_q <= '0;
				bank_q <= bank_q + grb_pkg::BANK_W'(1);
			end else begin
				fill_q <= n;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/grb_queue.sv
// Run queue between front and back; one slot per bank.
`default_nettype none

module grb_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  grb_pkg::run_desc_t   push_desc,
	input  wire                  pop,
	output logic                 full,
	output logic                 head_valid,
	output grb_pkg::run_desc_t   head_desc
);

	grb_pkg::run_desc_t          slot_q [grb_pkg::NBANK];
	logic [grb_pkg::BANK_W-1:0]  wr_ptr_q;
	logic [grb_pkg::BANK_W-1:0]  rd_ptr_q;
	logic [grb_pkg::QCNT_W-1:0]  count_q;

	assign full       = count_q == grb_pkg::QCNT_W'(grb_pkg::NBANK);
	assign head_valid = count_q != '0;
	assign head_desc  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + grb_pkg::BANK_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + grb_pkg::BANK_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + grb_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - grb_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/grb_back.sv
// Back end: value store and the drain sequencer that emits runs.
`default_nettype none

module grb_back (
	input  wire                          clk,
	input  wire                          arst_n,
	input  grb_pkg::store_wr_t           st_wr,
	input  wire                          run_valid,
	input  grb_pkg::run_desc_t           run_desc,
	output logic                         run_pop,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [grb_pkg::VAL_W-1:0]    out_value,
	output logic                         out_run_last,
	output logic                         out_seq_last
);

	logic [grb_pkg::VAL_W-1:0]  mem [grb_pkg::MEM_DEPTH];

	logic [grb_pkg::CNT_W-1:0]  pos_q;
	logic [grb_pkg::CNT_W-1:0]  rd_pos;
	logic [grb_pkg::ADDR_W-1:0] rd_addr;
	logic                       fin;
	logic                       issue;
	logic                       adv_out;
	logic                       adv_s1;

	logic                       valid_s1;
	logic [grb_pkg::VAL_W-1:0]  value_s1;
	logic                       run_last_s1;
	logic                       seq_last_s1;

	logic                       out_valid_q;
	logic [grb_pkg::VAL_W-1:0]  out_value_q;
	logic                       out_run_last_q;
	logic                       out_seq_last_q;

	always_ff @(posedge clk) begin
		if (st_wr.en) begin
			mem[st_wr.addr] <= st_wr.data;
		end
	end

	assign adv_out = !out_valid_q || out_ready;
	assign adv_s1  = !valid_s1 || adv_out;
	assign issue   = run_valid && adv_s1;
	assign fin     = (pos_q + grb_pkg::CNT_W'(1)) == run_desc.count;
	assign run_pop = issue && fin;

	always_comb begin
		if (run_desc.rev) begin
			rd_pos = run_desc.count - grb_pkg::CNT_W'(1) - pos_q;
		end else begin
			rd_pos = pos_q;
		end
		rd_addr = {run_desc.bank, rd_pos[grb_pkg::IDX_W-1:0]};
	end

	// read stage and output register: payload registers take no reset
	always_ff @(posedge clk) begin
		if (issue) begin
			value_s1    <= mem[rd_addr];
			run_last_s1 <= fin;
			seq_last_s1 <= fin && run_desc.seq_last;
		end
		if (adv_out && valid_s1) begin
			out_value_q    <= value_s1;
			out_run_last_q <= run_last_s1;
			out_seq_last_q <= seq_last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				pos_q <= fin ? '0 : pos_q + grb_pkg::CNT_W'(1);
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (adv_out) begin
				valid_s1 <= 1'b0;
			end
			if (adv_out) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_value    = out_value_q;
	assign out_run_last = out_run_last_q;
	assign out_seq_last = out_seq_last_q;

endmodule

`default_nettype wire

FILE: rtl/group_reversal_buffer_core.sv
// Top level of the group reversal buffer: front end, run queue and back end.
`default_nettype none

// Channel   Dir   Width  Contents
// s_*       in    32+1   request: tdata = value, tlast = end_of_list
// m_*       out   32+2   result:  tdata = out_value, tlast = run_last,
//                                 tuser = sequence_last
// cfg_*     in    5      group_size write, one register
//
// Flow: the front accepts a value while s_tready is high; a closed run of
// n values drains at one result per cycle while m_tready is high, each
// read passing the store read register, then the output register. Two
// banks of MAX_GROUP entries alternate, so the front fills one bank while
// the back drains the other; a stream of full groups sustains about one
// value per cycle in, bounded by the single store read port on output.
// Reset: arst_n clears fill count, bank pointers, queue and output valid;
// group_size returns to 2. Store contents stay as they are.
// Stalls: s_tready drops while both banks hold runs not yet drained;
// m_tready low holds the output register and the read stage behind it.

module group_reversal_buffer_core (
	input  wire                         clk,
	input  wire                         arst_n,
	// configuration
	input  wire                         cfg_we,
	input  wire  [grb_pkg::GS_W-1:0]    cfg_wdata,   // group_size
	// input stream
	input  wire                         s_tvalid,
	output logic                        s_tready,
	input  wire  [grb_pkg::VAL_W-1:0]   s_tdata,     // [31:0] value
	input  wire                         s_tlast,     // end_of_list
	// output stream
	output logic                        m_tvalid,
	input  wire                         m_tready,
	output logic [grb_pkg::VAL_W-1:0]   m_tdata,     // [31:0] out_value
	output logic                        m_tlast,     // run_last
	output logic                        m_tuser      // [0] sequence_last
);

	grb_pkg::store_wr_t st_wr;
	grb_pkg::run_desc_t push_desc;
	grb_pkg::run_desc_t head_desc;
	logic               q_full;
	logic               q_push;
	logic               q_pop;
	logic               head_valid;

	// Front: writes each value into the filling bank and closes a run when
	// the group is complete or the sequence ends.
	grb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_value  (s_tdata),
		.in_last   (s_tlast),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_desc    (push_desc),
		.st_wr     (st_wr)
	);

	// Queue of closed runs; its depth equals the bank count, so a free slot
	// also means a free bank.
	grb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_desc  (push_desc),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	// Back: walks the head run, reversed for a full group, in order for a
	// tail, and frees the bank once its last read is issued.
	grb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.st_wr        (st_wr),
		.run_valid    (head_valid),
		.run_desc     (head_desc),
		.run_pop      (q_pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_value    (m_tdata),
		.out_run_last (m_tlast),
		.out_seq_last (m_tuser)
	);

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for group_reversal_buffer_core: group reversal of a value stream.
`timescale 1ns / 100ps

module tb_top;
	import grb_pkg::*;

	localparam int ITEM_GOAL   = 450;
	localparam int SETTLE_CYC  = 8;    // read pipeline plus output register, with margin
	localparam int HOLD_CYC    = 300;  // long receiver hold-off
	localparam int QUIET_LIMIT = 2000; // cycles with no request or result moving

	// one request: tdata = value, tlast = end_of_list
	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             eol;
	} list_elem_t;

	// one result: tdata = out_value, tlast = run_last, tuser = sequence_last
	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             run_last;
		logic             seq_last;
	} emit_beat_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [GS_W-1:0]  cfg_wdata = '0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [VAL_W-1:0] s_tdata   = '0;
	logic             s_tlast   = 1'b0;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [VAL_W-1:0] m_tdata;
	logic             m_tlast;
	logic             m_tuser;

	group_reversal_buffer_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// stimulus waiting for the driver, and results the buffer owes us
	list_elem_t elems_to_send[$];
	emit_beat_t owed_beats[$];

	// shadow copy of the buffer state
	logic [VAL_W-1:0] held_values[MAX_GROUP];
	int unsigned      held_count = 0;
	logic [GS_W-1:0]  group_size_shadow = GS_RESET;

	int  mismatches   = 0;
	int  items_queued = 0;
	int  quiet_cycles = 0;
	bit  calm         = 1'b0; // no random idling on either side
	bit  hold_req     = 1'b0;
	bit  hold_taken   = 1'b0;
	int  hold_left    = 0;

	// Buffer one value; when a group closes or the list ends, queue the run it emits.
	function automatic void reverse_groups(logic [VAL_W-1:0] v, logic eol);
		int unsigned grp;
		int unsigned n;
		emit_beat_t  b;
		grp = group_size_shadow;
		if (grp == 0)
			grp = 1;
		if (grp > MAX_GROUP)
			grp = MAX_GROUP;
		if (held_count >= MAX_GROUP)
			held_count = MAX_GROUP - 1;
		held_values[held_count] = v;
		held_count++;
		n = held_count;
		if (n >= grp) begin
			// full group: newest first, even when it is the last element
			for (int unsigned i = 0; i < n; i++) begin
				b.value    = held_values[n - 1 - i];
				b.run_last = (i + 1 == n);
				b.seq_last = (i + 1 == n) && eol;
				owed_beats.push_back(b);
			end
			held_count = 0;
		end else if (eol) begin
			// short tail keeps arrival order
			for (int unsigned i = 0; i < n; i++) begin
				b.value    = held_values[i];
				b.run_last = (i + 1 == n);
				b.seq_last = (i + 1 == n);
				owed_beats.push_back(b);
			end
			held_count = 0;
		end
	endfunction

	// Request side: predict on acceptance, then present the next element or idle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				reverse_groups(s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (elems_to_send.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
					s_tvalid <= 1'b1;
					s_tdata  <= elems_to_send[0].value;
					s_tlast  <= elems_to_send[0].eol;
					void'(elems_to_send.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result side: check against the oldest owed beat, then choose tready.
	always @(posedge clk) begin
		emit_beat_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (owed_beats.size() == 0) begin
					$error("unexpected result: out_value %h run_last %b sequence_last %b",
						m_tdata, m_tlast, m_tuser);
					mismatches++;
				end else begin
					want = owed_beats.pop_front();
					if (m_tdata !== want.value) begin
						$error("out_value: expected %h, got %h", want.value, m_tdata);
						mismatches++;
					end
					if (m_tlast !== want.run_last) begin
						$error("run_last: expected %b, got %b", want.run_last, m_tlast);
						mismatches++;
					end
					if (m_tuser !== want.seq_last) begin
						$error("sequence_last: expected %b, got %b", want.seq_last, m_tuser);
						mismatches++;
					end
				end
			end
			if (hold_req && !hold_taken) begin
				hold_taken <= 1'b1;
				hold_left  <= HOLD_CYC;
				m_tready   <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else begin
				m_tready <= calm || $urandom_range(99) >= 9;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	task automatic queue_elem(logic [VAL_W-1:0] v, logic eol);
		list_elem_t e;
		e.value = v;
		e.eol   = eol;
		elems_to_send.push_back(e);
		items_queued++;
	endtask

	// Wait until every request went in and every owed result came out.
	task automatic wait_drained();
		@(negedge clk);
		while (elems_to_send.size() != 0 || s_tvalid || owed_beats.size() != 0)
			@(negedge clk);
	endtask

	// Register write only on a quiet block; a partial group may stay buffered.
	task automatic write_group_size(logic [GS_W-1:0] gs);
		wait_drained();
		repeat (SETTLE_CYC) @(posedge clk);
		cfg_we            <= 1'b1;
		cfg_wdata         <= gs;
		group_size_shadow  = gs;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(15))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'hffff_ffff;
			3:       return '0;
			default: return $urandom();
		endcase
	endfunction

	initial begin
		int               gs;
		int               grp;
		int               budget;
		int               len;
		int               phase;
		int               roll;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset group size 2: sign extremes, full group on the last element, single tail
		queue_elem(32'h8000_0000, 1'b0);
		queue_elem(32'h7fff_ffff, 1'b0);
		queue_elem(32'h0000_0000, 1'b0);
		queue_elem(32'hffff_ffff, 1'b1);
		queue_elem(32'h0000_0001, 1'b1);

		// short tail of two stays in order
		write_group_size(GS_W'(3));
		queue_elem(32'hdead_beef, 1'b0);
		queue_elem(32'h1234_5678, 1'b1);

		// zero group size behaves as pass-through
		write_group_size(GS_W'(0));
		queue_elem(32'ha5a5_a5a5, 1'b0);
		queue_elem(32'h5a5a_5a5a, 1'b1);

		// lower the size with three values held: next value flushes all four reversed
		write_group_size(GS_W'(4));
		queue_elem(32'h0000_0011, 1'b0);
		queue_elem(32'h0000_0022, 1'b0);
		queue_elem(32'h0000_0033, 1'b0);
		write_group_size(GS_W'(2));
		queue_elem(32'h0000_0044, 1'b0);

		phase = 0;
		while (items_queued < ITEM_GOAL) begin
			roll = $urandom_range(99);
			if (roll < 70)
				gs = $urandom_range(5, 1);
			else if (roll < 80)
				gs = ($urandom_range(2) == 0) ? 0 : (($urandom_range(1) == 0) ? 16 : 31);
			else
				gs = $urandom_range(31);
			if (phase == 2)
				gs = 3;
			if (phase == 4)
				gs = 4;
			write_group_size(GS_W'(gs));
			calm = (phase == 4);
			if (phase == 2)
				hold_req = 1'b1; // receiver stalls long while requests keep coming
			grp = (gs == 0) ? 1 : ((gs > MAX_GROUP) ? MAX_GROUP : gs);
			budget = (phase == 2 || phase == 4) ? 50 : $urandom_range(40, 15);
			while (budget > 0) begin
				if ($urandom_range(9) == 0) begin
					// noise: short bursts with arbitrary end flags
					len = $urandom_range(3, 1);
					for (int i = 0; i < len; i++)
						queue_elem(pick_value(), 1'($urandom_range(1)));
				end else begin
					len = $urandom_range(3 * grp + 2, 1);
					for (int i = 0; i < len; i++)
						queue_elem(pick_value(), i == len - 1);
				end
				budget -= len;
			end
			// sometimes leave a list unfinished so the next write may land mid-group
			if ($urandom_range(3) == 0) begin
				len = $urandom_range(grp, 1);
				for (int i = 0; i < len; i++)
					queue_elem(pick_value(), 1'b0);
			end
			phase++;
		end

		wait_drained();
		calm = 1'b0;
		repeat (4 * SETTLE_CYC) @(posedge clk);
		if (mismatches == 0 && owed_beats.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
